// ===== rtl/lccd_pkg.sv =====
// Shared types and constants for the LRU chunk cache directory.
package lccd_pkg;

   localparam int ENTRIES    = 64;
   localparam int KEY_BITS   = 48;
   localparam int RANK_BITS  = $clog2(ENTRIES);
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);

   localparam logic [1:0] MODE_LOOKUP   = 2'd0;
   localparam logic [1:0] MODE_INSERT   = 2'd1;
   localparam logic [1:0] MODE_CONTAINS = 2'd2;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;

   localparam logic [1:0] OP_NONE    = 2'd0;
   localparam logic [1:0] OP_TOUCH   = 2'd1;
   localparam logic [1:0] OP_DROP    = 2'd2;
   localparam logic [1:0] OP_INSTALL = 2'd3;

   localparam logic [1:0] REG_CHUNK_BYTES    = 2'd0;
   localparam logic [1:0] REG_CAPACITY_BYTES = 2'd1;

   // Command broadcast to every cell.
   typedef struct packed {
      logic [1:0]           op;
      logic [RANK_BITS-1:0] rank;
      logic [KEY_BITS-1:0]  key;
      logic [23:0]          size;
      logic [47:0]          stamp;
      logic [23:0]          charge;
   } lccd_cmd_type;

   // Data handed from one cell to the next.
   typedef struct packed {
      logic                 taken;
      logic                 hit;
      logic [RANK_BITS-1:0] hit_rank;
      logic [23:0]          hit_size;
      logic [31:0]          hit_count;
      logic [23:0]          hit_charge;
      logic [23:0]          tgt_charge;
   } lccd_link_type;

endpackage

// ===== rtl/lru_chunk_cache_directory.sv =====
// Top level of the fully associative LRU chunk cache directory.
// Each request takes one word and gives one response word. A lookup or
// contains probe is answered from the S_LOOK state through the registered
// response word; an insert with a valid size goes on from S_LOOK through
// S_EVICT and S_INSTALL, as the sequencer drops one
// least-recent entry per cycle through the cell row. A new request is taken
// once the sequencer is back in idle and the response register is free or
// being drained. Keys are matched in parallel in all 64 cells.
module lru_chunk_cache_directory (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,   // key[47:0], vsize[71:48]
   input  logic [1:0]   req_tuser,   // mode[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,   // entry_valid_size[23:0], entry_last_access[71:24],
                                     // entry_access_count[103:72], eviction_total[151:104]
   output logic         rsp_tuser,   // ok
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [39:0]  csr_wdata
);
   import lccd_pkg::*;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_LOOK    = 2'd1;
   localparam logic [1:0] S_EVICT   = 2'd2;
   localparam logic [1:0] S_INSTALL = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [23:0]           chunk_ff;
   logic [39:0]           cap_ff;
   logic [1:0]            mode_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [23:0]           vsize_ff;
   logic [39:0]           bytes_ff, bytes_in;
   logic [47:0]           tick_ff, tick_in;
   logic [47:0]           evict_ff, evict_in;
   logic [COUNT_BITS-1:0] n_ff, n_in;
   logic                  rvalid_ff, rvalid_in;
   logic                  rok_ff;
   logic [23:0]           rsize_ff;
   logic [47:0]           rstamp_ff;
   logic [31:0]           rcount_ff;
   logic                  done;
   logic                  done_ok;
   logic [23:0]           done_size;
   logic [47:0]           done_stamp;
   logic [31:0]           done_count;
   logic                  good, fits, accept;
   logic [40:0]           need;
   lccd_cmd_type          cmd;
   lccd_link_type         link;

   lccd_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .link_out (link)
   );

   assign req_tready = (state_ff == S_IDLE) && (!rvalid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign good       = (vsize_ff != 24'd0) && (vsize_ff <= chunk_ff) &&
                       (cap_ff != 40'd0) && ({16'd0, chunk_ff} <= cap_ff);
   assign need       = {1'b0, bytes_ff} + {17'd0, chunk_ff};
   assign fits       = (need <= {1'b0, cap_ff}) && (n_ff < COUNT_BITS'(ENTRIES));

   // Sequence one request through the cell row.
   always_comb begin
      state_in   = state_ff;
      bytes_in   = bytes_ff;
      tick_in    = tick_ff;
      evict_in   = evict_ff;
      n_in       = n_ff;
      done       = 1'b0;
      done_ok    = 1'b0;
      done_size  = '0;
      done_stamp = '0;
      done_count = '0;
      cmd        = '0;
      cmd.key    = key_ff;
      cmd.size   = vsize_ff;
      cmd.charge = chunk_ff;
      cmd.stamp  = tick_ff + 48'd1;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_LOOK;
         end
         S_LOOK: begin
            state_in = S_IDLE;
            done     = 1'b1;
            case (mode_ff)
               MODE_LOOKUP: begin
                  if (link.hit) begin
                     cmd.op     = OP_TOUCH;
                     cmd.rank   = link.hit_rank;
                     tick_in    = tick_ff + 48'd1;
                     done_ok    = 1'b1;
                     done_size  = link.hit_size;
                     done_stamp = tick_ff + 48'd1;
                     done_count = link.hit_count + 32'd1;
                  end
               end
               MODE_CONTAINS: done_ok = link.hit;
               MODE_INSERT: begin
                  if (good) begin
                     done     = 1'b0;
                     state_in = S_EVICT;
                     if (link.hit) begin
                        cmd.op   = OP_DROP;
                        cmd.rank = link.hit_rank;
                        bytes_in = bytes_ff - {16'd0, link.hit_charge};
                        n_in     = n_ff - 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_EVICT: begin
            if (n_ff == '0 || fits) begin
               state_in = S_INSTALL;
            end else begin
               cmd.op   = OP_DROP;
               cmd.rank = RANK_BITS'(n_ff - 1'b1);
               bytes_in = bytes_ff - {16'd0, link.tgt_charge};
               n_in     = n_ff - 1'b1;
               evict_in = evict_ff + 48'd1;
            end
         end
         S_INSTALL: begin
            cmd.op   = OP_INSTALL;
            tick_in  = tick_ff + 48'd1;
            bytes_in = need[39:0];
            n_in     = n_ff + 1'b1;
            done     = 1'b1;
            done_ok  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold or drain the response word.
   always_comb begin
      rvalid_in = rvalid_ff;
      if (rsp_tready) rvalid_in = 1'b0;
      if (done)       rvalid_in = 1'b1;
   end

   // Advance control state and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         bytes_ff  <= '0;
         tick_ff   <= '0;
         evict_ff  <= '0;
         n_ff      <= '0;
         rvalid_ff <= 1'b0;
         chunk_ff  <= 24'd4096;
         cap_ff    <= 40'd262144;
      end else begin
         state_ff  <= state_in;
         bytes_ff  <= bytes_in;
         tick_ff   <= tick_in;
         evict_ff  <= evict_in;
         n_ff      <= n_in;
         rvalid_ff <= rvalid_in;
         if (csr_we && csr_index == REG_CHUNK_BYTES)    chunk_ff <= csr_wdata[23:0];
         if (csr_we && csr_index == REG_CAPACITY_BYTES) cap_ff   <= csr_wdata;
      end
   end

   // Capture the request word and the response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_tuser;
         key_ff   <= req_tdata[KEY_BITS-1:0];
         vsize_ff <= req_tdata[71:48];
      end
      if (done) begin
         rok_ff    <= done_ok;
         rsize_ff  <= done_size;
         rstamp_ff <= done_stamp;
         rcount_ff <= done_count;
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tuser  = rok_ff;
   assign rsp_tdata  = {evict_ff, rcount_ff, rstamp_ff, rsize_ff};

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      n_ff <= COUNT_BITS'(ENTRIES))
      else $error("valid entry count out of range");

   a_empty_bytes: assert property (@(posedge clock) disable iff (reset)
      (n_ff == '0) |-> (bytes_ff == '0))
      else $error("bytes in use with empty directory");

   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOK))
      else $error("accepted word not looked up");

   a_busy_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("ready while busy");

endmodule

// ===== rtl/lccd_cell.sv =====
// One directory entry: key match, recency rank update and install.
module lccd_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lccd_pkg::lccd_cmd_type  cmd,
   input  lccd_pkg::lccd_link_type link_in,
   output lccd_pkg::lccd_link_type link_out
);
   import lccd_pkg::*;

   logic                 valid_ff, valid_in;
   logic [KEY_BITS-1:0]  key_ff;
   logic [23:0]          size_ff;
   logic [47:0]          stamp_ff;
   logic [31:0]          count_ff;
   logic [23:0]          charge_ff;
   logic [RANK_BITS-1:0] rank_ff, rank_in;
   logic                 match, target, install_me;

   assign match      = valid_ff && (key_ff == cmd.key);
   assign target     = valid_ff && (rank_ff == cmd.rank);
   assign install_me = !valid_ff && !link_in.taken;

   // Pass the free-slot priority and the OR of hit and target data along the row.
   always_comb begin
      link_out            = link_in;
      link_out.taken      = link_in.taken | !valid_ff;
      link_out.hit        = link_in.hit | match;
      if (match) begin
         link_out.hit_rank   = link_in.hit_rank | rank_ff;
         link_out.hit_size   = link_in.hit_size | size_ff;
         link_out.hit_count  = link_in.hit_count | count_ff;
         link_out.hit_charge = link_in.hit_charge | charge_ff;
      end
      if (target) begin
         link_out.tgt_charge = link_in.tgt_charge | charge_ff;
      end
   end

   // Next rank and valid bit for each command.
   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      case (cmd.op)
         OP_TOUCH: begin
            if (valid_ff && rank_ff < cmd.rank) rank_in = rank_ff + 1'b1;
            if (target) rank_in = '0;
         end
         OP_DROP: begin
            if (valid_ff && rank_ff > cmd.rank) rank_in = rank_ff - 1'b1;
            if (target) valid_in = 1'b0;
         end
         OP_INSTALL: begin
            if (valid_ff) rank_in = rank_ff + 1'b1;
            if (install_me) begin
               valid_in = 1'b1;
               rank_in  = '0;
            end
         end
         default: ;
      endcase
   end

   // Clear the valid bit under reset and update it otherwise.
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   // Update the entry payload.
   always_ff @(posedge clock) begin
      rank_ff <= rank_in;
      if (cmd.op == OP_TOUCH && target) begin
         stamp_ff <= cmd.stamp;
         count_ff <= count_ff + 32'd1;
      end
      if (cmd.op == OP_INSTALL && install_me) begin
         key_ff    <= cmd.key;
         size_ff   <= cmd.size;
         stamp_ff  <= cmd.stamp;
         count_ff  <= 32'd1;
         charge_ff <= cmd.charge;
      end
   end

endmodule

// ===== rtl/lccd_chain.sv =====
// Row of directory cells linked by their neighbor chain.
module lccd_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  lccd_pkg::lccd_cmd_type  cmd,
   output lccd_pkg::lccd_link_type link_out
);
   import lccd_pkg::*;

   lccd_link_type links [ENTRIES+1];

   assign links[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lccd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .link_in  (links[g]),
         .link_out (links[g+1])
      );
   end

   assign link_out = links[ENTRIES];

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the LRU chunk cache directory.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lccd_pkg::*;

   localparam int LIMIT_CYCLES = 400000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [71:0]  req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [151:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [39:0]  csr_wdata;

   lru_chunk_cache_directory dut (.*);

   typedef struct packed {
      logic        ok;
      logic [23:0] vsize;
      logic [47:0] stamp;
      logic [31:0] count;
      logic [47:0] evictions;
   } dir_result_type;

   typedef struct {
      logic [1:0]     mode;
      logic [47:0]    key;
      logic [23:0]    vsize;
      logic           has_exp;
      dir_result_type exp;
   } stim_row_type;

   // Shadow copy of the directory
   logic [23:0] sh_chunk;
   logic [39:0] sh_capacity;
   logic [47:0] sh_key [ENTRIES];
   logic        sh_valid [ENTRIES];
   logic [23:0] sh_size [ENTRIES];
   logic [47:0] sh_stamp [ENTRIES];
   logic [31:0] sh_count [ENTRIES];
   int          sh_rank [ENTRIES];
   logic [23:0] sh_charge [ENTRIES];
   logic [39:0] sh_used;
   logic [47:0] sh_tick;
   logic [47:0] sh_evict;

   dir_result_type pending_results [$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          hold_off_active;
   bit          no_idle;

   function automatic int find_slot(logic [47:0] k);
      for (int i = 0; i < ENTRIES; i++)
         if (sh_valid[i] && sh_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void drop_slot(int s);
      for (int i = 0; i < ENTRIES; i++)
         if (sh_valid[i] && sh_rank[i] > sh_rank[s]) sh_rank[i]--;
      sh_valid[s] = 1'b0;
      sh_used = sh_used - 40'(sh_charge[s]);
   endfunction

   // Predict one response and advance the shadow state
   function automatic dir_result_type directory_predict(logic [1:0] mode, logic [47:0] k,
                                                        logic [23:0] vs);
      dir_result_type r;
      int s, n, lru;
      r = '0;
      if (mode == MODE_LOOKUP) begin
         s = find_slot(k);
         if (s >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
               if (sh_valid[i] && sh_rank[i] < sh_rank[s]) sh_rank[i]++;
            sh_rank[s] = 0;
            sh_tick++;
            sh_stamp[s] = sh_tick;
            sh_count[s]++;
            r.ok = 1'b1;
            r.vsize = sh_size[s];
            r.stamp = sh_stamp[s];
            r.count = sh_count[s];
         end
      end else if (mode == MODE_CONTAINS) begin
         r.ok = find_slot(k) >= 0;
      end else if (mode == MODE_INSERT) begin
         if (vs != 0 && vs <= sh_chunk && sh_capacity != 0 && 40'(sh_chunk) <= sh_capacity)
         begin
            s = find_slot(k);
            if (s >= 0) drop_slot(s);
            forever begin
               n = 0;
               for (int i = 0; i < ENTRIES; i++) n += sh_valid[i];
               if (n == 0) break;
               if ({1'b0, sh_used} + 41'(sh_chunk) <= {1'b0, sh_capacity} && n < ENTRIES)
                  break;
               lru = -1;
               for (int i = 0; i < ENTRIES; i++)
                  if (sh_valid[i] && (lru < 0 || sh_rank[i] > sh_rank[lru])) lru = i;
               drop_slot(lru);
               sh_evict++;
            end
            s = -1;
            for (int i = 0; i < ENTRIES; i++)
               if (!sh_valid[i]) begin
                  s = i;
                  break;
               end
            for (int i = 0; i < ENTRIES; i++)
               if (sh_valid[i]) sh_rank[i]++;
            sh_valid[s] = 1'b1;
            sh_key[s] = k;
            sh_size[s] = vs;
            sh_tick++;
            sh_stamp[s] = sh_tick;
            sh_count[s] = 32'd1;
            sh_charge[s] = sh_chunk;
            sh_rank[s] = 0;
            sh_used = sh_used + 40'(sh_chunk);
            r.ok = 1'b1;
         end
      end
      r.evictions = sh_evict;
      return r;
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off
   initial begin
      int n;
      bit held;
      held = 1'b0;
      rsp_tready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off_active && !held) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            held = 1'b1;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 18);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 30);
            rsp_tready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   // Check responses against the oldest expectation
   always @(posedge clock) begin
      dir_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok = rsp_tuser;
         got.vsize = rsp_tdata[23:0];
         got.stamp = rsp_tdata[71:24];
         got.count = rsp_tdata[103:72];
         got.evictions = rsp_tdata[151:104];
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [39:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_CHUNK_BYTES) sh_chunk = val[23:0];
      else sh_capacity = val;
      @(posedge clock);
   endtask

   // Drop the request, wait for the directory to drain, then let it settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // Offer one word; predict when it is taken
   task automatic send_word(logic [1:0] mode, logic [47:0] k, logic [23:0] vs,
                            logic has_exp, dir_result_type exp_r);
      dir_result_type pr;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {vs, k};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pr = directory_predict(mode, k, vs);
      pending_results.push_back(has_exp ? exp_r : pr);
   endtask

   function automatic logic [47:0] pick_key(int pool);
      case ($urandom_range(0, 9))
         0: return 48'({$urandom, $urandom});
         1: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, pool));
         default: return 48'($urandom_range(0, pool));
      endcase
   endfunction

   function automatic logic [23:0] pick_size();
      case ($urandom_range(0, 11))
         0: return 24'd0;
         1: return sh_chunk + 24'd1;
         2: return sh_chunk;
         default: return 24'($urandom_range(1, sh_chunk));
      endcase
   endfunction

   task automatic random_phase(int items, int pool);
      logic [1:0] mode;
      logic [23:0] vs;
      for (int i = 0; i < items; i++) begin
         mode = $urandom_range(0, 20) == 0 ? MODE_UNUSED : 2'($urandom_range(0, 2));
         vs = $urandom_range(0, 15) == 0 ? 24'($urandom) : pick_size();
         send_word(mode, pick_key(pool), vs, 1'b0, '0);
      end
   endtask

   stim_row_type directed [13] = '{
      '{MODE_LOOKUP,   48'h0,            24'd0,       1'b1, '0},
      '{MODE_CONTAINS, 48'hFFFFFFFFFFFF, 24'hFFFFFF,  1'b1, '0},
      '{MODE_INSERT,   48'h1,            24'd0,       1'b1, '0},
      '{MODE_INSERT,   48'h1,            24'd4097,    1'b1, '0},
      '{MODE_INSERT,   48'hFFFFFFFFFFFF, 24'd4096,    1'b1, {1'b1, 24'd0, 48'd0, 32'd0, 48'd0}},
      '{MODE_INSERT,   48'h0,            24'd1,       1'b1, {1'b1, 24'd0, 48'd0, 32'd0, 48'd0}},
      '{MODE_LOOKUP,   48'hFFFFFFFFFFFF, 24'd0,       1'b1, {1'b1, 24'd4096, 48'd3, 32'd2, 48'd0}},
      '{MODE_CONTAINS, 48'h0,            24'd0,       1'b1, {1'b1, 24'd0, 48'd0, 32'd0, 48'd0}},
      '{MODE_INSERT,   48'h0,            24'd7,       1'b0, '0},
      '{MODE_LOOKUP,   48'h0,            24'd0,       1'b0, '0},
      '{MODE_UNUSED,   48'hAAAAAAAAAAAA, 24'hAAAAAA,  1'b1, '0},
      '{MODE_LOOKUP,   48'h555555555555, 24'h555555,  1'b1, '0},
      '{MODE_CONTAINS, 48'h1,            24'd0,       1'b1, '0}
   };

   // Stimulus
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      hold_off_active = 1'b0;
      no_idle = 1'b0;
      sh_chunk = 24'd4096;
      sh_capacity = 40'd262144;
      sh_used = '0;
      sh_tick = '0;
      sh_evict = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         sh_valid[i] = 1'b0;
         sh_rank[i] = 0;
         sh_charge[i] = '0;
         sh_count[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_word(directed[i].mode, directed[i].key, directed[i].vsize,
                   directed[i].has_exp, directed[i].exp);

      // Default sizes, full directory: 64 slots fit the default budget exactly
      hold_off_active = 1'b1;
      random_phase(200, 90);
      drain();

      // Small budget: frequent byte-driven evictions
      write_reg(REG_CHUNK_BYTES, 40'd16);
      write_reg(REG_CAPACITY_BYTES, 40'd100);
      random_phase(150, 20);
      drain();

      // Bad capacity settings: capacity zero, then chunk above capacity
      write_reg(REG_CAPACITY_BYTES, 40'd0);
      random_phase(15, 10);
      drain();
      write_reg(REG_CAPACITY_BYTES, 40'd15);
      random_phase(15, 10);
      drain();

      // Extremes: largest chunk, largest budget; chunk equal to budget
      write_reg(REG_CHUNK_BYTES, 40'hFFFFFF);
      write_reg(REG_CAPACITY_BYTES, 40'hFF_FFFF_FFFF);
      random_phase(150, 100);
      drain();
      write_reg(REG_CHUNK_BYTES, 40'd1);
      write_reg(REG_CAPACITY_BYTES, 40'd1);
      random_phase(40, 6);
      drain();

      // Last part without idling
      write_reg(REG_CHUNK_BYTES, 40'd300);
      write_reg(REG_CAPACITY_BYTES, 40'd9000);
      no_idle = 1'b1;
      random_phase(150, 50);
      drain();

      if (mismatches == 0 && pending_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
